### hw/rtl/lfsb_pkg.sv
// shared types and constants for the leftmost-free stack bank
`default_nettype none
package lfsb_pkg;

	localparam int NUM_STACKS  = 16;
	localparam int STACK_DEPTH = 16;
	localparam int VALUE_BITS  = 16;

	// fixed port widths
	localparam int OP_W     = 2;
	localparam int PORT_VAL = 16;
	localparam int STAT_W   = 2;
	localparam int IDX_W    = 4;
	localparam int CAP_W    = 5;

	// derived widths
	localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int SIDX_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int RAM_DEPTH = NUM_STACKS * STACK_DEPTH;
	localparam int ADDR_W  = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
	localparam logic [OP_W-1:0] OP_POP    = 2'd1;
	localparam logic [OP_W-1:0] OP_POP_AT = 2'd2;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

	// count update request for one cell
	typedef struct packed {
		logic inc;
		logic dec;
	} cell_cmd_t;

	// what one cell reports to the controller
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             push_hit;
		logic             pop_hit;
		logic             nonempty;
	} cell_stat_t;

endpackage
`default_nettype wire

### hw/rtl/leftmost_free_stack_bank.sv
// top level: bank of stacks, push leftmost non-full, pop rightmost non-empty
//
//  channel | signals                                   | dir | notes
//  --------+-------------------------------------------+-----+--------------------------
//  cfg     | cfg_wr_en, cfg_wr_data[4:0]               | in  | stack capacity, no wait
//  in      | in_valid/in_ready, op, push_value,        | in  | one item per operation
//          | stack_index                               |     |
//  out     | out_valid/out_ready, popped_value,        | out | one item per input item
//          | status, touched_stack                     |     |
//
// a push, or a pop that finds nothing, goes from the accept through the search state, which
// searches along the chain of fill-count cells, and back to idle; a pop that takes a value
// also passes the read state, for the registered read of the plate ram. reset clears
// every fill count and sets the capacity to 16; plate ram contents are never cleared.
// a result waiting in the output register does not block the next accept; the item after
// it stalls in its search or read cycle until the output is free.
`default_nettype none
module leftmost_free_stack_bank (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [lfsb_pkg::CAP_W-1:0]    cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [lfsb_pkg::OP_W-1:0]     op,
	input  wire logic [lfsb_pkg::PORT_VAL-1:0] push_value,
	input  wire logic [lfsb_pkg::IDX_W-1:0]    stack_index,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [lfsb_pkg::PORT_VAL-1:0]      popped_value,
	output logic [lfsb_pkg::STAT_W-1:0]        status,
	output logic [lfsb_pkg::IDX_W-1:0]         touched_stack
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEL,
		ST_READ
	} state_t;

	localparam int N = lfsb_pkg::NUM_STACKS;

	state_t state_q;

	// configuration
	logic [lfsb_pkg::CAP_W-1:0] cap_q;
	logic [lfsb_pkg::CNT_W-1:0] eff_cap;

	// accepted item
	logic [lfsb_pkg::OP_W-1:0]       op_q;
	logic [lfsb_pkg::VALUE_BITS-1:0] value_q;
	logic [lfsb_pkg::IDX_W-1:0]      index_q;

	// target stack held across the ram read
	logic [lfsb_pkg::SIDX_W-1:0] tgt_q;

	// cell chain
	lfsb_pkg::cell_cmd_t  cmd  [N];
	lfsb_pkg::cell_stat_t stat [N];
	logic [N:0]           push_link;
	logic [N:0]           pop_link;

	// search results
	logic [lfsb_pkg::SIDX_W-1:0] push_sel;
	logic [lfsb_pkg::SIDX_W-1:0] pop_sel;
	logic [lfsb_pkg::SIDX_W-1:0] at_sel;
	logic                        at_ok;
	logic                        at_nonempty;

	// decision for the item in the search cycle
	logic [lfsb_pkg::SIDX_W-1:0] tgt;
	logic [lfsb_pkg::CNT_W-1:0]  tgt_count;
	logic                        do_push;
	logic                        do_pop;
	logic [lfsb_pkg::STAT_W-1:0] res_status;
	logic [lfsb_pkg::IDX_W-1:0]  res_touched;

	logic                        out_free;
	logic                        res_load;
	logic                        commit_push;
	logic                        commit_pop;
	logic [lfsb_pkg::ADDR_W-1:0] base_addr;
	logic [lfsb_pkg::ADDR_W-1:0] wr_addr;
	logic [lfsb_pkg::ADDR_W-1:0] rd_addr;
	logic [lfsb_pkg::VALUE_BITS-1:0] rd_data;

	// capacity of zero acts as one, anything past the depth as the depth
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = lfsb_pkg::CNT_W'(1);
		end else if (32'(cap_q) > lfsb_pkg::STACK_DEPTH) begin
			eff_cap = lfsb_pkg::CNT_W'(lfsb_pkg::STACK_DEPTH);
		end else begin
			eff_cap = lfsb_pkg::CNT_W'(cap_q);
		end
	end

	assign push_link[0] = 1'b0;
	assign pop_link[N]  = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		lfsb_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cap           (eff_cap),
			.push_seen_in  (push_link[i]),
			.pop_seen_in   (pop_link[i+1]),
			.cmd           (cmd[i]),
			.push_seen_out (push_link[i+1]),
			.pop_seen_out  (pop_link[i]),
			.stat          (stat[i])
		);
	end

	// one-hot hits to index; at most one hit per chain
	always_comb begin
		push_sel = '0;
		pop_sel  = '0;
		for (int i = 0; i < N; i++) begin
			if (stat[i].push_hit) begin
				push_sel = push_sel | lfsb_pkg::SIDX_W'(i);
			end
			if (stat[i].pop_hit) begin
				pop_sel = pop_sel | lfsb_pkg::SIDX_W'(i);
			end
		end
	end

	// pop at index: stacks past the bank read as empty
	assign at_ok       = (32'(index_q) < N);
	assign at_sel      = lfsb_pkg::SIDX_W'(index_q);
	assign at_nonempty = at_ok && stat[at_sel].nonempty;

	always_comb begin
		tgt         = '0;
		do_push     = 1'b0;
		do_pop      = 1'b0;
		res_status  = lfsb_pkg::STATUS_EMPTY;
		res_touched = '0;
		case (op_q)
			lfsb_pkg::OP_PUSH: begin
				if (push_link[N]) begin
					tgt         = push_sel;
					do_push     = 1'b1;
					res_status  = lfsb_pkg::STATUS_OK;
					res_touched = lfsb_pkg::IDX_W'(push_sel);
				end else begin
					res_status = lfsb_pkg::STATUS_FULL;
				end
			end
			lfsb_pkg::OP_POP: begin
				if (pop_link[0]) begin
					tgt    = pop_sel;
					do_pop = 1'b1;
				end
			end
			lfsb_pkg::OP_POP_AT: begin
				res_touched = index_q;
				if (at_nonempty) begin
					tgt    = at_sel;
					do_pop = 1'b1;
				end
			end
			default: begin
				res_status = lfsb_pkg::STATUS_EMPTY;
			end
		endcase
	end

	assign tgt_count = stat[tgt].count;

	assign out_free    = ~out_valid | out_ready;
	assign commit_push = (state_q == ST_SEL) && out_free && do_push;
	assign commit_pop  = (state_q == ST_SEL) && out_free && do_pop;

	// a result enters the output register this cycle
	assign res_load = out_free && (((state_q == ST_SEL) && !do_pop) || (state_q == ST_READ));

	for (genvar i = 0; i < N; i++) begin : g_cmd
		assign cmd[i].inc = commit_push && (tgt == lfsb_pkg::SIDX_W'(i));
		assign cmd[i].dec = commit_pop && (tgt == lfsb_pkg::SIDX_W'(i));
	end

	// plate address: stack base plus slot within the stack
	assign base_addr = lfsb_pkg::ADDR_W'(tgt) * lfsb_pkg::ADDR_W'(lfsb_pkg::STACK_DEPTH);
	assign wr_addr   = base_addr + lfsb_pkg::ADDR_W'(tgt_count);
	assign rd_addr   = base_addr + lfsb_pkg::ADDR_W'(tgt_count - 1'b1);

	lfsb_ram #(
		.WIDTH (lfsb_pkg::VALUE_BITS),
		.DEPTH (lfsb_pkg::RAM_DEPTH)
	) u_plates (
		.clk     (clk),
		.wr_en   (commit_push),
		.wr_addr (wr_addr),
		.wr_data (value_q),
		.rd_en   (commit_pop),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfsb_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= op;
			value_q <= lfsb_pkg::VALUE_BITS'(push_value);
			index_q <= stack_index;
		end
		if (commit_pop) begin
			tgt_q <= tgt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid     <= 1'b0;
			popped_value  <= '0;
			status        <= lfsb_pkg::STATUS_OK;
			touched_stack <= '0;
		end else begin
			if (res_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (out_free) begin
						if (do_pop) begin
							state_q <= ST_READ;
						end else begin
							// push or nothing to take: result straight away
							popped_value  <= '0;
							status        <= res_status;
							touched_stack <= res_touched;
							state_q       <= ST_IDLE;
						end
					end
				end
				ST_READ: begin
					if (out_free) begin
						popped_value  <= lfsb_pkg::PORT_VAL'(rd_data);
						status        <= lfsb_pkg::STATUS_OK;
						touched_stack <= lfsb_pkg::IDX_W'(tgt_q);
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lfsb_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module lfsb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lfsb_cell.sv
// one stack's fill count with its links in the two search chains
`default_nettype none
module lfsb_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [lfsb_pkg::CNT_W-1:0] cap,
	input  wire logic                       push_seen_in,
	input  wire logic                       pop_seen_in,
	input  wire lfsb_pkg::cell_cmd_t        cmd,
	output logic                            push_seen_out,
	output logic                            pop_seen_out,
	output lfsb_pkg::cell_stat_t            stat
);

	logic [lfsb_pkg::CNT_W-1:0] count_q;
	logic                       not_full;
	logic                       nonempty;

	assign not_full = (count_q < cap);
	assign nonempty = (count_q != '0);

	// push chain runs left to right, pop chain right to left
	assign push_seen_out = push_seen_in | not_full;
	assign pop_seen_out  = pop_seen_in | nonempty;

	assign stat.count    = count_q;
	assign stat.push_hit = ~push_seen_in & not_full;
	assign stat.pop_hit  = ~pop_seen_in & nonempty;
	assign stat.nonempty = nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.inc) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.dec) begin
			count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### tb/bank_tb_pkg.sv
// result type and scoreboard class for the stack bank testbench
package bank_tb_pkg;
	timeunit 1ns;
	timeprecision 1ps;
	import lfsb_pkg::*;

	// op code the block leaves unused
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [PORT_VAL-1:0] value;
		logic [STAT_W-1:0]   stat;
		logic [IDX_W-1:0]    stack;
	} bank_result_t;

	class plate_bank_tracker;
		logic [PORT_VAL-1:0] plates [NUM_STACKS][STACK_DEPTH];
		int unsigned fill [NUM_STACKS];
		logic [CAP_W-1:0] capacity;
		bank_result_t pending_results [$];
		int unsigned error_count;
		int unsigned checked_count;
		int unsigned values_popped;
		int unsigned empty_pops;
		int unsigned full_drops;

		function new();
			foreach (fill[i])
				fill[i] = 0;
			capacity = CAP_RESET;
			error_count = 0;
			checked_count = 0;
			values_popped = 0;
			empty_pops = 0;
			full_drops = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] cap);
			capacity = cap;
		endfunction

		function int unsigned pending_count();
			return pending_results.size();
		endfunction

		// top of one stack, or an empty status naming that stack
		function bank_result_t take_plate(int s);
			bank_result_t got;
			got.value = '0;
			got.stack = IDX_W'(s);
			if (fill[s] == 0) begin
				got.stat = STATUS_EMPTY;
				empty_pops++;
			end else begin
				fill[s]--;
				got.value = plates[s][fill[s]];
				got.stat = STATUS_OK;
				values_popped++;
			end
			return got;
		endfunction

		function void note_request(logic [OP_W-1:0] code, logic [PORT_VAL-1:0] value,
				logic [IDX_W-1:0] idx);
			bank_result_t want;
			int unsigned depth_limit;
			want.value = '0;
			want.stat = STATUS_EMPTY;
			want.stack = '0;
			case (code)
				OP_PUSH: begin
					// zero acts as one, anything above the depth as the depth
					depth_limit = (capacity == 0) ? 1 :
						((capacity > STACK_DEPTH) ? STACK_DEPTH : capacity);
					want.stat = STATUS_FULL;
					for (int s = 0; s < NUM_STACKS; s++) begin
						if (fill[s] < depth_limit) begin
							plates[s][fill[s]] = value;
							fill[s]++;
							want.stat = STATUS_OK;
							want.stack = IDX_W'(s);
							break;
						end
					end
					if (want.stat == STATUS_FULL)
						full_drops++;
				end
				OP_POP: begin
					for (int s = NUM_STACKS - 1; s >= 0; s--) begin
						if (fill[s] != 0) begin
							want = take_plate(s);
							break;
						end
					end
					if (want.stat == STATUS_EMPTY)
						empty_pops++;
				end
				OP_POP_AT: begin
					want = take_plate(int'(idx));
				end
				default: begin
				end
			endcase
			pending_results.push_back(want);
		endfunction

		function void check_result(logic [PORT_VAL-1:0] value, logic [STAT_W-1:0] stat,
				logic [IDX_W-1:0] stack);
			bank_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: value %h status %0d stack %0d",
					$time, value, stat, stack);
				error_count++;
				return;
			end
			want = pending_results.pop_front();
			checked_count++;
			if (value !== want.value) begin
				$display("%0t: popped_value expected %h actual %h", $time, want.value, value);
				error_count++;
			end
			if (stat !== want.stat) begin
				$display("%0t: status expected %0d actual %0d", $time, want.stat, stat);
				error_count++;
			end
			if (stack !== want.stack) begin
				$display("%0t: touched_stack expected %0d actual %0d", $time, want.stack, stack);
				error_count++;
			end
		endfunction
	endclass

endpackage

### tb/tb_top.sv
// testbench top: drives the stack bank and checks every result item
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lfsb_pkg::*;
	import bank_tb_pkg::*;

	// generous ceiling on the whole run, in clock cycles
	localparam int RUN_LIMIT     = 400000;
	// idle cycles after the last result before touching the capacity
	localparam int SETTLE_CYCLES = 8;
	// length of a deliberate receiver hold-off
	localparam int LONG_HOLD     = 250;
	localparam int PHASE_ITEMS   = 50;
	localparam int PHASE_COUNT   = 13;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [CAP_W-1:0]    cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     op = OP_PUSH;
	logic [PORT_VAL-1:0] push_value = '0;
	logic [IDX_W-1:0]    stack_index = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [PORT_VAL-1:0] popped_value;
	logic [STAT_W-1:0]   status;
	logic [IDX_W-1:0]    touched_stack;

	plate_bank_tracker bank = new();

	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned caps_written = 0;
	// bumped by the stimulus, served by the result sink
	int unsigned hold_requests = 0;
	// when set the sender offers items back to back
	bit steady_sender = 1'b0;

	leftmost_free_stack_bank uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.push_value   (push_value),
		.stack_index  (stack_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.popped_value (popped_value),
		.status       (status),
		.touched_stack(touched_stack)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("run limit of %0d cycles reached, %0d results still due",
				RUN_LIMIT, bank.pending_count());
			$display("FAIL");
			$finish;
		end
	end

	// offer one item after a random gap and hold it until accepted
	// valid is only lowered when a gap follows, so back to back items
	// never see valid dropped and raised in the same step
	task automatic send_item(input logic [OP_W-1:0] code, input logic [PORT_VAL-1:0] value,
			input logic [IDX_W-1:0] idx);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (steady_sender || r < 55)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		push_value <= value;
		stack_index <= idx;
		do
			@(posedge clk);
		while (!in_ready);
		bank.note_request(code, value, idx);
		items_sent++;
	endtask

	// stop offering and wait for every outstanding result, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (bank.pending_count() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// capacity changes only while the bank is idle
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		bank.set_capacity(cap);
		caps_written++;
	endtask

	// result side: check each accepted item, then pick the next ready level
	initial begin : result_sink
		int stall_left;
		int quiet_left;
		int hold_left;
		int unsigned holds_served;
		int r;
		stall_left = 0;
		quiet_left = 0;
		hold_left = 0;
		holds_served = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				bank.check_result(popped_value, status, touched_stack);
			// long hold-off counted here so the input side backs up
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (quiet_left > 0) begin
				quiet_left--;
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 8)
					quiet_left = $urandom_range(20, 80);
				else if (r < 12)
					stall_left = $urandom_range(10, 40);
				else if (r < 40)
					stall_left = $urandom_range(1, 3);
				out_ready <= (stall_left == 0);
			end
		end
	end

	initial begin : stimulus
		int phase;
		int n;
		int r;
		int push_pct;
		logic [OP_W-1:0] code;
		logic [CAP_W-1:0] cap;
		// first settings: tiny, out-of-range high, lowered below current fill, zero
		logic [CAP_W-1:0] phase_caps [9] = '{5'd1, 5'd31, 5'd3, 5'd2, 5'd17, 5'd5,
			5'd0, 5'd16, 5'd4};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty bank, unused op, extreme values, reset capacity
		send_item(OP_POP, 16'h0000, 4'd0);
		send_item(OP_POP_AT, 16'hffff, 4'd15);
		send_item(OP_UNUSED, 16'hffff, 4'd15);
		send_item(OP_PUSH, 16'hffff, 4'd15);
		send_item(OP_PUSH, 16'h0000, 4'd0);
		send_item(OP_POP_AT, 16'h0000, 4'd0);
		send_item(OP_POP, 16'h5a5a, 4'd7);
		send_item(OP_POP, 16'ha5a5, 4'd8);

		// capacity zero behaves as one: sixteen pushes fill the bank, the next is dropped
		set_capacity(5'd0);
		for (n = 0; n < NUM_STACKS + 1; n++)
			send_item(OP_PUSH, PORT_VAL'($urandom), IDX_W'($urandom));

		// random phases, contents carried over so lowered capacities see overfull stacks
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			cap = (phase < 9) ? phase_caps[phase] : CAP_W'($urandom_range(0, 31));
			set_capacity(cap);
			push_pct = $urandom_range(35, 75);
			steady_sender = ($urandom_range(0, 2) == 0);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// receiver stalls while items keep coming in
				if (n == 10 && (phase == 1 || phase == 6))
					hold_requests <= hold_requests + 1;
				r = $urandom_range(0, 99);
				if (r < push_pct)
					code = OP_PUSH;
				else if (r < push_pct + (100 - push_pct) / 2)
					code = OP_POP_AT;
				else if (r < 97)
					code = OP_POP;
				else
					code = OP_UNUSED;
				send_item(code, PORT_VAL'($urandom), IDX_W'($urandom));
			end
		end
		steady_sender = 1'b0;

		drain();
		$display("%0d items sent, %0d results checked, %0d capacity settings", items_sent,
			bank.checked_count, caps_written);
		$display("%0d values popped, %0d pops found nothing, %0d pushes dropped on a full bank",
			bank.values_popped, bank.empty_pops, bank.full_drops);
		if (bank.error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
